>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console tile writer
// Request/result payloads, decoded command format, back-end states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int POS_W      = 5;
  localparam int CELL_W     = 8;
  localparam int SCREEN_AW  = 10;
  localparam int MAP_AW     = SCREEN_AW + 1;
  localparam int MAP_DEPTH  = 1 << MAP_AW;

  localparam int MAP_COLUMNS_DEF  = 32;
  localparam int VISIBLE_ROWS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [CELL_W-1:0] BLANK_CELL       = 8'h20;
  localparam logic [CELL_W-1:0] CODE_LINE_FEED   = 8'd10;
  localparam logic [CELL_W-1:0] CODE_CARRIAGE_RET = 8'd13;

  localparam logic [1:0] REQ_WRITE      = 2'd0;
  localparam logic [1:0] REQ_SET_CURSOR = 2'd1;
  localparam logic [1:0] REQ_READ       = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CELL_W-1:0] char_code;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_column;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } res_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUT,
    CMD_LINE_FEED,
    CMD_RETURN,
    CMD_SET_CURSOR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CELL_W-1:0] code;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_READ_WAIT,
    B_SCROLL
  } back_state_t;

endpackage

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: request intake and classification
// Takes a request, decodes it into a command and hands it to the queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  input  logic clearing,
  input  logic q_ready,
  output logic push,
  output cmd_t push_cmd
);

  logic fvalid;
  cmd_t cmd;
  logic accept;

  function automatic cmd_t classify(input req_t r);
    cmd_t c;
    c.code   = r.char_code;
    c.row    = r.row;
    c.column = r.column;
    unique case (r.req_type)
      REQ_WRITE: begin
        if (r.char_code == CODE_LINE_FEED) begin
          c.kind = CMD_LINE_FEED;
        end else if (r.char_code == CODE_CARRIAGE_RET) begin
          c.kind = CMD_RETURN;
        end else begin
          c.kind = CMD_PUT;
        end
      end
      REQ_SET_CURSOR: c.kind = CMD_SET_CURSOR;
      REQ_READ:       c.kind = CMD_READ;
      default:        c.kind = CMD_NONE;
    endcase
    return c;
  endfunction

  assign busy     = clearing || (fvalid && !q_ready);
  assign accept   = start && !busy;
  assign push     = fvalid && q_ready;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
    if (accept) begin
      cmd <= classify(req);
    end
  end

endmodule

>>> rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: command queue between front and back
// Small register FIFO so either side can stall on its own.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic not_empty,
  output logic not_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign not_full  = (count != CNT_W'(DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < CNT_W'(DEPTH)))
    else $error("command queue overflow");

endmodule

>>> rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: command execution
// Owns the tile map and both cursors; prints, scrolls, reads, clears.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int MAP_COLUMNS  = MAP_COLUMNS_DEF,
  parameter int VISIBLE_ROWS = VISIBLE_ROWS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic screen_select,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic clearing,
  output logic done,
  output res_t result
);

  localparam int SCROLL_CELLS = VISIBLE_ROWS * MAP_COLUMNS;
  localparam int SCROLL_W     = $clog2(SCROLL_CELLS + 1);
  localparam int POS1_W       = POS_W + 1;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [POS_W-1:0]    cur_row [2];
  logic [POS_W-1:0]    cur_col [2];
  logic [MAP_AW-1:0]   clr_cnt;
  logic [SCROLL_W-1:0] scroll_cnt;

  logic              ram_we;
  logic [MAP_AW-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [MAP_AW-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [POS_W-1:0]  row_cur, col_cur, row_next, col_next;
  logic [POS1_W-1:0] row_inc, col_inc;
  logic              wrap, new_row, overflow, scroll_last, clr_last;
  logic              cur_we, res_fire;
  res_t              res_next;

  function automatic logic [SCREEN_AW-1:0] cell_off(input logic [POS_W-1:0] r,
                                                    input logic [POS_W-1:0] c);
    return SCREEN_AW'(32'(r) * MAP_COLUMNS + 32'(c));
  endfunction

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_cur     = cur_row[screen_select];
  assign col_cur     = cur_col[screen_select];
  assign row_inc     = {1'b0, row_cur} + 1'b1;
  assign col_inc     = {1'b0, col_cur} + 1'b1;
  assign wrap        = (cur.kind == CMD_PUT) && (col_inc > POS1_W'(MAP_COLUMNS - 1));
  assign new_row     = (cur.kind == CMD_LINE_FEED) || wrap;
  assign overflow    = new_row && (row_inc > POS1_W'(VISIBLE_ROWS - 1));
  assign scroll_last = (scroll_cnt == SCROLL_W'(SCROLL_CELLS));
  assign clr_last    = (clr_cnt == MAP_AW'(MAP_DEPTH - 1));
  assign clearing    = (state == B_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR:     if (clr_last) state_next = B_IDLE;
      B_IDLE:      if (q_valid) state_next = B_EXEC;
      B_EXEC: begin
        if (cur.kind == CMD_READ) begin
          state_next = B_READ_WAIT;
        end else if (overflow) begin
          state_next = B_SCROLL;
        end else begin
          state_next = B_IDLE;
        end
      end
      B_READ_WAIT: state_next = B_IDLE;
      B_SCROLL:    if (scroll_last) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  // outputs: map port, cursor update, result
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = cur.code;
    ram_raddr = '0;
    cur_we    = 1'b0;
    row_next  = row_cur;
    col_next  = col_cur;
    res_fire  = 1'b0;
    res_next  = '{cursor_row: row_cur, cursor_column: col_cur,
                  cell_value: '0, scrolled: 1'b0};
    unique case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = BLANK_CELL;
      end
      B_IDLE: q_pop = q_valid;
      B_EXEC: begin
        cur_we = 1'b1;
        unique case (cur.kind)
          CMD_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = {screen_select, cell_off(row_cur, col_cur)};
            col_next  = col_inc[POS_W-1:0];
          end
          CMD_RETURN: col_next = '0;
          CMD_SET_CURSOR: begin
            row_next = cur.row;
            col_next = cur.column;
          end
          CMD_READ: ram_raddr = {screen_select, cell_off(cur.row, cur.column)};
          default: ;
        endcase
        if (new_row) begin
          col_next = '0;
          row_next = overflow ? POS_W'(VISIBLE_ROWS - 1) : row_inc[POS_W-1:0];
        end
        res_fire               = (cur.kind != CMD_READ) && !overflow;
        res_next.cursor_row    = row_next;
        res_next.cursor_column = col_next;
      end
      B_READ_WAIT: begin
        res_fire            = 1'b1;
        res_next.cell_value = ram_rdata;
      end
      B_SCROLL: begin
        // read one row ahead, write the cell fetched last cycle
        ram_raddr = {screen_select, SCREEN_AW'(32'(scroll_cnt) + MAP_COLUMNS)};
        ram_we    = (scroll_cnt != '0);
        ram_waddr = {screen_select, SCREEN_AW'(32'(scroll_cnt) - 32'd1)};
        ram_wdata = ram_rdata;
        res_fire          = scroll_last;
        res_next.scrolled = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_cnt    <= '0;
      scroll_cnt <= '0;
      cur_row[0] <= '0;
      cur_row[1] <= '0;
      cur_col[0] <= '0;
      cur_col[1] <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_fire;
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == B_SCROLL) begin
        scroll_cnt <= scroll_cnt + 1'b1;
      end else begin
        scroll_cnt <= '0;
      end
      if (cur_we) begin
        cur_row[screen_select] <= row_next;
        cur_col[screen_select] <= col_next;
      end
    end
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (res_fire) begin
      result <= res_next;
    end
  end

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (done && result.scrolled) |->
      (result.cursor_row == POS_W'(VISIBLE_ROWS - 1) && result.cursor_column == '0))
    else $error("scroll result with cursor off the last visible row");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR && !clr_last) |=> (state == B_CLEAR))
    else $error("clearing pass left early");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> (state != B_IDLE && state != B_CLEAR))
    else $error("result without a command in progress");

endmodule

>>> rtl/text_console_tile_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_tile_writer_core: two-screen text console over a tile map
// Prints characters, handles line feed / return, scrolls, places the cursor
// and reads cells, each screen with its own map region and cursor.
// ----------------------------------------------------------------------------
//  channel   | signals                        | flow
//  ----------+--------------------------------+------------------------------
//  request   | start, busy, req               | taken when start && !busy
//  result    | done, result                   | one-cycle strobe, no stall
//  config    | cfg_valid, cfg_ready, cfg_data | screen_select, always ready
//
//  a request passes the front register and the command queue before the
//  back end pops it into its command register; a read also waits for the
//  registered map read, and a scroll copies VISIBLE_ROWS * MAP_COLUMNS cells,
//  one cell per cycle through the single map write port.
//  after reset the map is filled with blanks, one cell per cycle, all 2048
//  cells; busy stays high meanwhile, config writes are still taken.
//  the front and back stall apart through a small command queue; the
//  receiver cannot stall, so results never back up.
// ----------------------------------------------------------------------------
module text_console_tile_writer_core import tcw_pkg::*; #(
  parameter int MAP_COLUMNS  = MAP_COLUMNS_DEF,
  parameter int VISIBLE_ROWS = VISIBLE_ROWS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic screen_select;
  logic clearing;
  logic q_ready, q_valid, push, pop;
  cmd_t push_cmd, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_select <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      screen_select <= cfg_data;
    end
  end

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .clearing (clearing),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tcw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .not_full  (q_ready)
  );

  tcw_back #(
    .MAP_COLUMNS  (MAP_COLUMNS),
    .VISIBLE_ROWS (VISIBLE_ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_select (screen_select),
    .q_valid       (q_valid),
    .q_cmd         (head),
    .q_pop         (pop),
    .clearing      (clearing),
    .done          (done),
    .result        (result)
  );

endmodule

>>> sim/text_console_tile_writer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_tile_writer_core_test: self-checking bench for the console core
// Drives character, set-cursor, read and unused requests on both screens,
// keeps its own copy of both map regions and cursors, and checks every result
// field against the expected cursor report, in order. Random gaps on requests.
// ----------------------------------------------------------------------------
module text_console_tile_writer_core_test;
  import tcw_pkg::*;

  localparam int COLS         = MAP_COLUMNS_DEF;
  localparam int ROWS         = VISIBLE_ROWS_DEF;
  localparam int SCREEN_CELLS = 1 << SCREEN_AW;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS  = 300;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam bit SCREEN_BOTTOM = 1'b0;
  localparam bit SCREEN_TOP    = 1'b1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic start     = 1'b0;
  logic busy;
  req_t req       = '0;
  logic done;
  res_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;

  // console state as the block should hold it
  logic [CELL_W-1:0] console_map [0:MAP_DEPTH-1];
  int cursor_row_of [0:1];
  int cursor_col_of [0:1];
  bit active_screen;

  req_t pending_requests [$];
  res_t expected_cursor_reports [$];
  int   gap_left;
  bit   gaps_on;
  int   error_count;
  int   cycle_count;

  text_console_tile_writer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 50) $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic int map_addr(input int scr, input int r, input int c);
    return scr * SCREEN_CELLS + ((r * COLS + c) & (SCREEN_CELLS - 1));
  endfunction

  // new row; past the last visible row the map moves up one row
  task automatic advance_row(input int scr, inout int r, inout int c, inout bit rolled);
    int base;
    r = r + 1;
    c = 0;
    if (r > ROWS - 1) begin
      base = scr * SCREEN_CELLS;
      for (int i = 0; i < ROWS * COLS; i++)
        console_map[base + (i & (SCREEN_CELLS - 1))] =
          console_map[base + ((i + COLS) & (SCREEN_CELLS - 1))];
      r = ROWS - 1;
      rolled = 1'b1;
    end
  endtask

  task automatic console_step(input req_t rq);
    int   scr;
    int   r;
    int   c;
    bit   rolled;
    res_t rep;
    scr = active_screen;
    r = cursor_row_of[scr];
    c = cursor_col_of[scr];
    rolled = 1'b0;
    rep = '0;
    case (rq.req_type)
      REQ_WRITE: begin
        if (rq.char_code == CODE_LINE_FEED) begin
          advance_row(scr, r, c, rolled);
          c = 0;
        end else if (rq.char_code == CODE_CARRIAGE_RET) begin
          c = 0;
        end else begin
          console_map[map_addr(scr, r, c)] = rq.char_code;
          c = c + 1;
        end
        if (c > COLS - 1) advance_row(scr, r, c, rolled);
      end
      REQ_SET_CURSOR: begin
        r = rq.row;
        c = rq.column;
      end
      REQ_READ: begin
        rep.cell_value = console_map[map_addr(scr, rq.row, rq.column)];
      end
      default: ;
    endcase
    cursor_row_of[scr] = r & 31;
    cursor_col_of[scr] = c & 31;
    rep.cursor_row    = cursor_row_of[scr][POS_W-1:0];
    rep.cursor_column = cursor_col_of[scr][POS_W-1:0];
    rep.scrolled      = rolled;
    expected_cursor_reports.push_back(rep);
  endtask

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // request driver: one transfer per start && !busy edge
  always @(posedge clk) begin : request_driver
    bit fire;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        console_step(req);
        gap_left = pick_gap();
      end
      if (fire || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req   <= pending_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst && done) begin
      if (expected_cursor_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", result));
      end else begin
        want = expected_cursor_reports.pop_front();
        if (result.cursor_row !== want.cursor_row)
          report_mismatch($sformatf("cursor_row %0d, want %0d",
                                    result.cursor_row, want.cursor_row));
        if (result.cursor_column !== want.cursor_column)
          report_mismatch($sformatf("cursor_column %0d, want %0d",
                                    result.cursor_column, want.cursor_column));
        if (result.cell_value !== want.cell_value)
          report_mismatch($sformatf("cell_value %h, want %h",
                                    result.cell_value, want.cell_value));
        if (result.scrolled !== want.scrolled)
          report_mismatch($sformatf("scrolled %b, want %b",
                                    result.scrolled, want.scrolled));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] code,
                                    input int r, input int c);
    req_t rq;
    rq.req_type  = kind;
    rq.char_code = code;
    rq.row       = r[POS_W-1:0];
    rq.column    = c[POS_W-1:0];
    return rq;
  endfunction

  task automatic write_screen(input bit scr);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= scr;
    do @(posedge clk); while (!cfg_ready);
    // transfer taken at this edge
    active_screen = scr;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || start || expected_cursor_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic req_t random_request();
    req_t rq;
    int   pick;
    rq = make_req(REQ_WRITE, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                  $urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if (pick < 4) rq.char_code = CODE_LINE_FEED;
      else if (pick < 7) rq.char_code = CODE_CARRIAGE_RET;
    end else if (pick < 72) begin
      rq.req_type = REQ_SET_CURSOR;
    end else if (pick < 97) begin
      rq.req_type = REQ_READ;
    end else begin
      rq.req_type = REQ_UNUSED;
    end
    return rq;
  endfunction

  // mostly runs of text, which wrap and scroll, mixed with single requests
  task automatic load_random(input int count);
    int loaded;
    int run;
    req_t rq;
    loaded = 0;
    while (loaded < count) begin
      if ($urandom_range(0, 3) == 0) begin
        run = $urandom_range(4, 40);
        for (int i = 0; i < run; i++) begin
          rq = random_request();
          rq.req_type = REQ_WRITE;
          pending_requests.push_back(rq);
        end
        loaded += run;
      end else begin
        pending_requests.push_back(random_request());
        loaded++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) console_map[i] = BLANK_CELL;
    cursor_row_of = '{0, 0};
    cursor_col_of = '{0, 0};
    active_screen = SCREEN_TOP;
    error_count = 0;
    cycle_count = 0;
    gaps_on = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_screen(SCREEN_TOP);

    // top screen: printing, controls, wrap, scroll from every path, reads
    pending_requests.push_back(make_req(REQ_READ, 8'h00, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h41, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h00, 31, 31));
    pending_requests.push_back(make_req(REQ_WRITE, 8'hff, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, CODE_CARRIAGE_RET, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, CODE_LINE_FEED, 0, 0));
    pending_requests.push_back(make_req(REQ_SET_CURSOR, 8'h00, 0, 31));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h7e, 0, 0));
    pending_requests.push_back(make_req(REQ_SET_CURSOR, 8'h00, 23, 30));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h78, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h79, 0, 0));
    pending_requests.push_back(make_req(REQ_SET_CURSOR, 8'h00, 23, 5));
    pending_requests.push_back(make_req(REQ_WRITE, CODE_LINE_FEED, 0, 0));
    pending_requests.push_back(make_req(REQ_SET_CURSOR, 8'hff, 31, 31));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h80, 0, 0));
    pending_requests.push_back(make_req(REQ_SET_CURSOR, 8'h00, 31, 0));
    pending_requests.push_back(make_req(REQ_WRITE, CODE_LINE_FEED, 31, 31));
    pending_requests.push_back(make_req(REQ_READ, 8'hff, 31, 31));
    pending_requests.push_back(make_req(REQ_READ, 8'h00, 22, 1));
    pending_requests.push_back(make_req(REQ_UNUSED, 8'hff, 31, 31));
    pending_requests.push_back(make_req(REQ_SET_CURSOR, 8'h00, 24, 0));
    pending_requests.push_back(make_req(REQ_WRITE, CODE_CARRIAGE_RET, 0, 0));
    drain();

    // bottom screen keeps its own map and cursor
    write_screen(SCREEN_BOTTOM);
    pending_requests.push_back(make_req(REQ_READ, 8'h00, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 8'h42, 0, 0));
    pending_requests.push_back(make_req(REQ_READ, 8'h00, 0, 0));
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_screen(ph % 2 == 0 ? SCREEN_BOTTOM : SCREEN_TOP);
      gaps_on = (ph != 2);
      load_random(PHASE_ITEMS);
      drain();
    end

    if (expected_cursor_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_cursor_reports.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
